FILE: src/icmp_pkg.sv
package icmp_pkg;

    // Widths fixed by the register and word layout
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int SIZE_W      = 5;
    localparam int PAYLOAD_MAX = 16;

    // Reset values of the configuration registers
    localparam logic [15:0]       PERIOD_RESET  = 16'd1000;
    localparam logic [15:0]       TIMEOUT_RESET = 16'd3000;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 5'd4;

    // Type 8, code 0 as the first header word of an echo request
    localparam logic [15:0] ECHO_REQ_WORD = 16'h0800;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PING_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ECHO_ID      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_HIGH = 3'd6;

    // Input command codes
    localparam logic [1:0] CMD_WRITE_READY = 2'd0;
    localparam logic [1:0] CMD_TICK        = 2'd1;
    localparam logic [1:0] CMD_REPLY       = 2'd2;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_NONE     = 2'd0,
        KIND_SENT     = 2'd1,
        KIND_ACCEPTED = 2'd2,
        KIND_DROPPED  = 2'd3
    } t_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted input word
        logic exec;      // evaluate the command and update session state
        logic sum;       // add one payload word to the checksum
        logic fold;      // fold carries and complement
        logic emit;      // move the staged result to the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic send;      // the command evaluated this cycle sends a request
        logic last_word; // the current payload word is the last one
        logic out_free;  // output register can take a result this cycle
    } t_dp_status;

endpackage

FILE: src/icmp_echo_ping_engine.sv
// Channel   Direction  Handshake            Word
// input     in         i_valid / o_ready    i_cmd, i_length_ok, i_reply_*
// output    out        o_valid / i_ready    o_kind, o_ident, o_seq, o_checksum, o_finished
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One word at a time: an accepted word passes EXEC, then SUM and FOLD if it sends a
// request, then EMIT, and the next input word is taken only after that; the checksum adder
// takes one 16-bit payload word per cycle. The result shows once EMIT moves it to the
// output register.
// Synchronous active-low reset clears session state and loads register defaults.
// A result waits in the output register while the next input word is taken;
// the block stalls only when a new result is ready and that register is still full.
module icmp_echo_ping_engine #(
    parameter int PAYLOAD_BYTES = icmp_pkg::PAYLOAD_MAX
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [icmp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [icmp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_cmd,
    input  logic                              i_length_ok,
    input  logic [7:0]                        i_reply_type,
    input  logic [7:0]                        i_reply_code,
    input  logic [15:0]                       i_reply_ident,
    input  logic [15:0]                       i_reply_seq,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [1:0]                        o_kind,
    output logic [15:0]                       o_ident,
    output logic [15:0]                       o_seq,
    output logic [15:0]                       o_checksum,
    output logic                              o_finished
);
    import icmp_pkg::*;

    t_dp_cmd    w_dcmd;
    t_dp_status w_status;

    // Sequencer
    icmp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_dcmd)
    );

    // Session state, checksum and output register
    icmp_dp #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_length_ok   (i_length_ok),
        .i_reply_type  (i_reply_type),
        .i_reply_code  (i_reply_code),
        .i_reply_ident (i_reply_ident),
        .i_reply_seq   (i_reply_seq),
        .i_out_ready   (i_ready),
        .i_dcmd        (w_dcmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_ident       (o_ident),
        .o_seq         (o_seq),
        .o_checksum    (o_checksum),
        .o_finished    (o_finished)
    );

endmodule

FILE: src/icmp_ctrl.sv
module icmp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  icmp_pkg::t_dp_status  i_status,
    output icmp_pkg::t_dp_cmd     o_cmd
);
    import icmp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SUM  = 5'b00100,
        S_FOLD = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: n_state = i_status.send ? S_SUM : S_EMIT;
            S_SUM:  if (i_status.last_word) n_state = S_FOLD;
            S_FOLD: n_state = S_EMIT;
            S_EMIT: if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command decode
    assign o_ready       = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.sum     = (r_state == S_SUM);
    assign o_cmd.fold    = (r_state == S_FOLD);
    assign o_cmd.emit    = (r_state == S_EMIT) && i_status.out_free;

    // An accepted word is always evaluated next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> (r_state == S_EXEC))
        else $error("accepted word not evaluated");

    // Checksum loop runs exactly when a request is sent
    a_sum_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> ((r_state == S_SUM) == $past(i_status.send)))
        else $error("checksum loop does not follow send decision");

endmodule

FILE: src/icmp_dp.sv
module icmp_dp #(
    parameter int PAYLOAD_BYTES = icmp_pkg::PAYLOAD_MAX
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [icmp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [icmp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [1:0]                        i_cmd,
    input  logic                              i_length_ok,
    input  logic [7:0]                        i_reply_type,
    input  logic [7:0]                        i_reply_code,
    input  logic [15:0]                       i_reply_ident,
    input  logic [15:0]                       i_reply_seq,
    input  logic                              i_out_ready,
    input  icmp_pkg::t_dp_cmd                 i_dcmd,
    output icmp_pkg::t_dp_status              o_status,
    output logic                              o_valid,
    output logic [1:0]                        o_kind,
    output logic [15:0]                       o_ident,
    output logic [15:0]                       o_seq,
    output logic [15:0]                       o_checksum,
    output logic                              o_finished
);
    import icmp_pkg::*;

    localparam int WORDS = (PAYLOAD_BYTES + 1) / 2;
    localparam int SH_W  = 16 * WORDS;
    localparam logic [SIZE_W-1:0] LAST_POS  = SIZE_W'(2 * (WORDS - 1));
    localparam logic [SIZE_W-1:0] SIZE_SAT  = SIZE_W'(PAYLOAD_BYTES);

    // Configuration registers
    logic [15:0]           r_ping_limit, r_period_ms, r_timeout_ms, r_echo_id;
    logic [SIZE_W-1:0]     r_payload_size;
    logic [63:0]           r_payload_low, r_payload_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_limit   <= '0;
            r_period_ms    <= PERIOD_RESET;
            r_timeout_ms   <= TIMEOUT_RESET;
            r_echo_id      <= '0;
            r_payload_size <= SIZE_RESET;
            r_payload_low  <= '0;
            r_payload_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PING_LIMIT:   r_ping_limit   <= i_cfg_data[15:0];
                REG_PERIOD_MS:    r_period_ms    <= i_cfg_data[15:0];
                REG_TIMEOUT_MS:   r_timeout_ms   <= i_cfg_data[15:0];
                REG_ECHO_ID:      r_echo_id      <= i_cfg_data[15:0];
                REG_PAYLOAD_SIZE: r_payload_size <= i_cfg_data[SIZE_W-1:0];
                REG_PAYLOAD_LOW:  r_payload_low  <= i_cfg_data;
                REG_PAYLOAD_HIGH: r_payload_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Captured input word
    logic [1:0]  r_cmd;
    logic        r_length_ok;
    logic [7:0]  r_reply_type, r_reply_code;
    logic [15:0] r_reply_ident, r_reply_seq;

    always_ff @(posedge i_clk) begin
        if (i_dcmd.capture) begin
            r_cmd         <= i_cmd;
            r_length_ok   <= i_length_ok;
            r_reply_type  <= i_reply_type;
            r_reply_code  <= i_reply_code;
            r_reply_ident <= i_reply_ident;
            r_reply_seq   <= i_reply_seq;
        end
    end

    // Session state
    logic [15:0] r_sent, r_recv, r_countdown;
    logic        r_timer, r_over;
    logic [15:0] n_sent, n_recv, n_countdown;
    logic        n_timer, n_over;

    // Staged result
    t_kind       r_res_kind, n_res_kind;
    logic [15:0] r_res_ident, n_res_ident;
    logic [15:0] r_res_seq, n_res_seq;
    logic [15:0] r_res_csum;

    logic        n_send;
    logic [15:0] w_sent_inc, w_recv_inc;
    logic        w_match;

    assign w_sent_inc = r_sent + 16'd1;
    assign w_recv_inc = r_recv + 16'd1;
    assign w_match    = r_length_ok && (r_reply_type == 8'd0) && (r_reply_code == 8'd0)
                        && (r_reply_ident == r_echo_id);

    // Command evaluation
    always_comb begin
        n_sent      = r_sent;
        n_recv      = r_recv;
        n_countdown = r_countdown;
        n_timer     = r_timer;
        n_over      = r_over;
        n_res_kind  = KIND_NONE;
        n_res_ident = '0;
        n_res_seq   = '0;
        n_send      = 1'b0;
        if (!r_over) begin
            case (r_cmd)
                CMD_WRITE_READY: begin
                    if (r_sent == 16'd0) begin
                        if (r_sent >= r_ping_limit) begin
                            n_over      = 1'b1;
                            n_timer     = 1'b0;
                            n_countdown = '0;
                        end else begin
                            n_send      = 1'b1;
                            n_sent      = w_sent_inc;
                            n_res_kind  = KIND_SENT;
                            n_res_seq   = w_sent_inc;
                            n_countdown = r_period_ms;
                            n_timer     = 1'b1;
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_timer) begin
                        if (r_countdown > 16'd1) begin
                            n_countdown = r_countdown - 16'd1;
                        end else if (r_sent >= r_ping_limit) begin
                            n_over      = 1'b1;
                            n_timer     = 1'b0;
                            n_countdown = '0;
                        end else begin
                            n_send      = 1'b1;
                            n_sent      = w_sent_inc;
                            n_res_kind  = KIND_SENT;
                            n_res_seq   = w_sent_inc;
                            n_countdown = (w_sent_inc == r_ping_limit) ? r_timeout_ms
                                                                       : r_period_ms;
                        end
                    end
                end
                CMD_REPLY: begin
                    if (w_match) begin
                        n_recv      = w_recv_inc;
                        n_res_kind  = KIND_ACCEPTED;
                        n_res_ident = r_reply_ident;
                        n_res_seq   = r_reply_seq;
                        if (w_recv_inc >= r_ping_limit) begin
                            n_over      = 1'b1;
                            n_timer     = 1'b0;
                            n_countdown = '0;
                        end
                    end else begin
                        n_res_kind = KIND_DROPPED;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent      <= '0;
            r_recv      <= '0;
            r_countdown <= '0;
            r_timer     <= 1'b0;
            r_over      <= 1'b0;
            r_res_kind  <= KIND_NONE;
        end else if (i_dcmd.exec) begin
            r_sent      <= n_sent;
            r_recv      <= n_recv;
            r_countdown <= n_countdown;
            r_timer     <= n_timer;
            r_over      <= n_over;
            r_res_kind  <= n_res_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dcmd.exec) begin
            r_res_ident <= n_res_ident;
            r_res_seq   <= n_res_seq;
        end
    end

    // Checksum: one payload word per cycle from a shift register
    logic [19:0]       r_acc;
    logic [SH_W-1:0]   r_shift;
    logic [SIZE_W-1:0] r_pos;
    logic [SIZE_W-1:0] w_size_n, w_pos_odd;
    logic [15:0]       w_word;
    logic [16:0]       w_fold1;
    logic [16:0]       w_fold2;
    logic [127:0]      w_payload;

    assign w_payload = {r_payload_low, r_payload_high};
    assign w_size_n  = (r_payload_size > SIZE_SAT) ? SIZE_SAT : r_payload_size;
    assign w_pos_odd = r_pos + SIZE_W'(1);
    assign w_word    = {(r_pos < w_size_n)     ? r_shift[SH_W-1 -: 8] : 8'd0,
                        (w_pos_odd < w_size_n) ? r_shift[SH_W-9 -: 8] : 8'd0};
    assign w_fold1   = 17'(r_acc[19:16]) + 17'(r_acc[15:0]);
    assign w_fold2   = 17'(w_fold1[16]) + 17'(w_fold1[15:0]);

    always_ff @(posedge i_clk) begin
        if (i_dcmd.exec) begin
            r_acc   <= 20'(ECHO_REQ_WORD) + 20'(r_echo_id) + 20'(w_sent_inc);
            r_shift <= w_payload[127 -: SH_W];
            r_pos   <= '0;
        end else if (i_dcmd.sum) begin
            r_acc   <= r_acc + 20'(w_word);
            r_shift <= r_shift << 16;
            r_pos   <= r_pos + SIZE_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dcmd.exec) begin
            r_res_csum <= '0;
        end else if (i_dcmd.fold) begin
            r_res_csum <= ~w_fold2[15:0];
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dcmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dcmd.emit) begin
            o_kind     <= r_res_kind;
            o_ident    <= r_res_ident;
            o_seq      <= r_res_seq;
            o_checksum <= r_res_csum;
            o_finished <= r_over;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status.send      = n_send;
    assign o_status.last_word = (r_pos == LAST_POS);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // An ended session has its timer stopped and cleared
    a_over_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_over |-> (!r_timer && (r_countdown == 16'd0)))
        else $error("timer active after session end");

    // A staged request carries the current sent count
    a_sent_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_kind == KIND_SENT) |-> (r_res_seq == r_sent))
        else $error("request sequence differs from sent count");

    // The summing pass never walks past the last payload word
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dcmd.sum |-> (r_pos <= LAST_POS))
        else $error("checksum pass overran payload");

endmodule

FILE: sim/icmp_echo_ping_engine_tb.sv
module icmp_echo_ping_engine_tb;
    import icmp_pkg::*;

    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [15:0] LIMIT_MAX     = 16'hffff;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          SEGMENTS      = 10;
    localparam int          SEGMENT_WORDS = 100;
    localparam int          REPORT_MAX    = 40;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] ident;
        logic [15:0] seq;
        logic [15:0] checksum;
        logic        finished;
    } echo_result_t;

    // Session predictor plus the queue of results still owed by the block
    class echo_session_scoreboard;
        logic [15:0]       ping_limit;
        logic [15:0]       period_ms;
        logic [15:0]       timeout_ms;
        logic [15:0]       echo_id;
        logic [SIZE_W-1:0] payload_size;
        logic [63:0]       payload_low;
        logic [63:0]       payload_high;

        logic [15:0] sent_count;
        logic [15:0] received_count;
        logic [15:0] countdown;
        bit          timer_running;
        bit          session_over;

        echo_result_t owed_results[$];
        int errors, checked, words;
        int n_sent, n_accepted, n_dropped, n_none;

        function new();
            ping_limit     = '0;
            period_ms      = PERIOD_RESET;
            timeout_ms     = TIMEOUT_RESET;
            echo_id        = '0;
            payload_size   = SIZE_RESET;
            payload_low    = '0;
            payload_high   = '0;
            sent_count     = '0;
            received_count = '0;
            countdown      = '0;
            timer_running  = 1'b0;
            session_over   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PING_LIMIT:   ping_limit   = data[15:0];
                REG_PERIOD_MS:    period_ms    = data[15:0];
                REG_TIMEOUT_MS:   timeout_ms   = data[15:0];
                REG_ECHO_ID:      echo_id      = data[15:0];
                REG_PAYLOAD_SIZE: payload_size = data[SIZE_W-1:0];
                REG_PAYLOAD_LOW:  payload_low  = data;
                REG_PAYLOAD_HIGH: payload_high = data;
                default: ;
            endcase
        endfunction

        // One's complement sum over header words and big-endian payload pairs
        function logic [15:0] request_checksum(logic [15:0] seq);
            logic [127:0] payload_bits;
            logic [31:0]  acc;
            logic [15:0]  pair;
            int           n;
            payload_bits = {payload_low, payload_high};
            n = (payload_size > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(payload_size);
            acc = 32'(ECHO_REQ_WORD) + 32'(echo_id) + 32'(seq);
            for (int i = 0; i < n; i += 2) begin
                pair = {payload_bits[127 - 8*i -: 8], 8'h00};
                // odd tail byte stays padded with zero
                if (i + 1 < n) pair[7:0] = payload_bits[119 - 8*i -: 8];
                acc += 32'(pair);
            end
            acc = (acc >> 16) + (acc & 32'h0000ffff);
            acc = (acc >> 16) + (acc & 32'h0000ffff);
            return ~acc[15:0];
        endfunction

        function bit try_send(inout echo_result_t res);
            if (sent_count >= ping_limit) return 1'b0;
            sent_count   = sent_count + 16'd1;
            res.kind     = KIND_SENT;
            res.seq      = sent_count;
            res.checksum = request_checksum(sent_count);
            return 1'b1;
        endfunction

        function void end_session();
            session_over  = 1'b1;
            timer_running = 1'b0;
            countdown     = '0;
        endfunction

        // Accepted input word: advance the session and queue its result
        function void note_word(logic [1:0] cmd, logic len_ok, logic [7:0] rtype,
                                logic [7:0] rcode, logic [15:0] rident, logic [15:0] rseq);
            echo_result_t res;
            res      = '0;
            res.kind = KIND_NONE;
            words++;
            if (!session_over) begin
                case (cmd)
                    CMD_WRITE_READY: begin
                        if (sent_count == 16'd0) begin
                            if (try_send(res)) begin
                                countdown     = period_ms;
                                timer_running = 1'b1;
                            end else begin
                                end_session();
                            end
                        end
                    end
                    CMD_TICK: begin
                        if (timer_running) begin
                            if (countdown > 16'd1) begin
                                countdown = countdown - 16'd1;
                            end else if (!try_send(res)) begin
                                end_session();
                            end else begin
                                countdown = (sent_count == ping_limit) ? timeout_ms : period_ms;
                            end
                        end
                    end
                    CMD_REPLY: begin
                        if (len_ok && rtype == 8'd0 && rcode == 8'd0 && rident == echo_id) begin
                            received_count = received_count + 16'd1;
                            res.kind  = KIND_ACCEPTED;
                            res.ident = rident;
                            res.seq   = rseq;
                            if (received_count >= ping_limit) end_session();
                        end else begin
                            res.kind = KIND_DROPPED;
                        end
                    end
                    default: ;
                endcase
            end
            res.finished = session_over;
            owed_results.push_back(res);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= REPORT_MAX) $display("MISMATCH: %s", msg);
        endtask

        task check_result(logic [1:0] kind, logic [15:0] ident, logic [15:0] seq,
                          logic [15:0] checksum, logic finished);
            echo_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result with nothing owed: kind %0d seq %0d", kind, seq));
                return;
            end
            want = owed_results.pop_front();
            checked++;
            case (want.kind)
                KIND_SENT:     n_sent++;
                KIND_ACCEPTED: n_accepted++;
                KIND_DROPPED:  n_dropped++;
                default:       n_none++;
            endcase
            if (kind !== want.kind)
                report($sformatf("result %0d kind %0d, want %0d", checked, kind, want.kind));
            if (ident !== want.ident)
                report($sformatf("result %0d ident %h, want %h", checked, ident, want.ident));
            if (seq !== want.seq)
                report($sformatf("result %0d seq %h, want %h", checked, seq, want.seq));
            if (checksum !== want.checksum)
                report($sformatf("result %0d checksum %h, want %h",
                                 checked, checksum, want.checksum));
            if (finished !== want.finished)
                report($sformatf("result %0d finished %b, want %b",
                                 checked, finished, want.finished));
        endtask
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic [1:0]            i_cmd         = '0;
    logic                  i_length_ok   = 1'b0;
    logic [7:0]            i_reply_type  = '0;
    logic [7:0]            i_reply_code  = '0;
    logic [15:0]           i_reply_ident = '0;
    logic [15:0]           i_reply_seq   = '0;
    logic                  i_ready       = 1'b0;
    logic                  o_ready;
    logic                  o_valid;
    logic [1:0]            o_kind;
    logic [15:0]           o_ident;
    logic [15:0]           o_seq;
    logic [15:0]           o_checksum;
    logic                  o_finished;

    echo_session_scoreboard sb;
    int tx_idle_pct  = 36;
    int rx_idle_pct  = 81;
    int quiet_cycles = 0;
    int n_settings   = 0;

    icmp_echo_ping_engine DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_length_ok   (i_length_ok),
        .i_reply_type  (i_reply_type),
        .i_reply_code  (i_reply_code),
        .i_reply_ident (i_reply_ident),
        .i_reply_seq   (i_reply_seq),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_ident       (o_ident),
        .o_seq         (o_seq),
        .o_checksum    (o_checksum),
        .o_finished    (o_finished)
    );

    initial forever #4 i_clk = ~i_clk;

    // Result check, random receiver stalls and the no-progress watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_kind, o_ident, o_seq, o_checksum, o_finished);
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance
    task automatic put_word(logic [1:0] cmd, logic len_ok, logic [7:0] rtype,
                            logic [7:0] rcode, logic [15:0] rident, logic [15:0] rseq);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_cmd         <= cmd;
        i_length_ok   <= len_ok;
        i_reply_type  <= rtype;
        i_reply_code  <= rcode;
        i_reply_ident <= rident;
        i_reply_seq   <= rseq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_word(cmd, len_ok, rtype, rcode, rident, rseq);
    endtask

    // Hold the input until every owed result is out, then let the block settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [15:0] limit, logic [15:0] period, logic [15:0] timeout,
                                logic [15:0] id, logic [SIZE_W-1:0] size,
                                logic [63:0] lo, logic [63:0] hi);
        logic [CFG_IDX_W-1:0]  regs [7] = '{REG_PING_LIMIT, REG_PERIOD_MS, REG_TIMEOUT_MS,
                                            REG_ECHO_ID, REG_PAYLOAD_SIZE,
                                            REG_PAYLOAD_LOW, REG_PAYLOAD_HIGH};
        logic [CFG_DATA_W-1:0] vals [7];
        vals = '{64'(limit), 64'(period), 64'(timeout), 64'(id), 64'(size), lo, hi};
        for (int r = 0; r < 7; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= regs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            sb.write_reg(regs[r], vals[r]);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly ticks and well-formed replies; some broken replies and junk
    task automatic put_random_word();
        int          pick;
        logic [63:0] junk;
        logic        ok;
        logic [7:0]  rtype;
        logic [7:0]  rcode;
        logic [15:0] rident;
        pick   = $urandom_range(0, 99);
        junk   = {$urandom, $urandom};
        ok     = 1'b1;
        rtype  = 8'd0;
        rcode  = 8'd0;
        rident = sb.echo_id;
        if (pick < 45) begin
            put_word(CMD_TICK, junk[0], junk[8:1], junk[16:9], junk[32:17], junk[48:33]);
        end else if (pick < 92) begin
            if (pick >= 80) begin
                case ($urandom_range(0, 4))
                    0: ok     = 1'b0;
                    1: rtype  = 8'($urandom_range(1, 255));
                    2: rcode  = 8'($urandom_range(1, 255));
                    3: rident = sb.echo_id ^ 16'($urandom_range(1, 65535));
                    default: begin
                        ok     = junk[0];
                        rtype  = junk[8:1];
                        rcode  = junk[16:9];
                        rident = junk[32:17];
                    end
                endcase
            end
            put_word(CMD_REPLY, ok, rtype, rcode, rident, junk[63:48]);
        end else if (pick < 96) begin
            put_word(CMD_WRITE_READY, junk[0], junk[8:1], junk[16:9], junk[32:17],
                     junk[48:33]);
        end else begin
            put_word(CMD_UNUSED, junk[0], junk[8:1], junk[16:9], junk[32:17], junk[48:33]);
        end
    endtask

    initial begin
        logic [15:0] id;
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings have a zero limit: only words that cannot end the session
        put_word(CMD_UNUSED, 1'b1, 8'hff, 8'hff, 16'hffff, 16'hffff);
        put_word(CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        put_word(CMD_REPLY, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h1234);
        put_word(CMD_REPLY, 1'b1, 8'hff, 8'h00, 16'h0000, 16'h0001);
        put_word(CMD_REPLY, 1'b1, 8'h00, 8'hff, 16'h0000, 16'h0002);
        put_word(CMD_REPLY, 1'b1, 8'h00, 8'h00, 16'hffff, 16'h0003);
        drain_results();

        // All-ones payload at full size pushes the carry fold hardest
        program_regs(LIMIT_MAX, 16'd1, 16'd0, 16'hffff, 5'd16, '1, '1);
        put_word(CMD_REPLY, 1'b1, 8'h00, 8'h00, 16'hffff, 16'hffff);   // before start
        put_word(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        put_word(CMD_WRITE_READY, 1'b1, 8'hff, 8'hff, 16'hffff, 16'hffff);
        put_word(CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        put_word(CMD_TICK, 1'b1, 8'hff, 8'hff, 16'hffff, 16'hffff);
        put_word(CMD_REPLY, 1'b1, 8'h00, 8'h00, 16'hffff, 16'h0000);
        put_word(CMD_UNUSED, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        drain_results();

        // Oversized payload saturates; then empty and odd sizes
        program_regs(LIMIT_MAX, 16'd1, 16'd0, 16'h0000, 5'd31,
                     64'h0123456789abcdef, 64'hfedcba9876543210);
        put_word(CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        drain_results();
        program_regs(LIMIT_MAX, 16'd1, 16'd0, 16'h0000, 5'd0,
                     64'h0123456789abcdef, 64'hfedcba9876543210);
        put_word(CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        drain_results();
        program_regs(LIMIT_MAX, 16'd1, 16'd0, 16'h0000, 5'd15,
                     64'h0123456789abcdef, 64'hfedcba9876543210);
        put_word(CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        drain_results();

        // Last request reloads with the zero timeout; raise the limit before it fires
        program_regs(sb.sent_count + 16'd1, 16'd1, 16'd0, 16'h0000, 5'd15,
                     64'h0123456789abcdef, 64'hfedcba9876543210);
        put_word(CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);
        drain_results();
        program_regs(LIMIT_MAX, 16'd2, TIMEOUT_RESET, 16'h0000, 5'd15,
                     64'h0123456789abcdef, 64'hfedcba9876543210);
        put_word(CMD_TICK, 1'b0, 8'h00, 8'h00, 16'h0000, 16'h0000);

        // Random segments, each with fresh settings and one of three idle mixes
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            tx_idle_pct = (seg < 4) ? 36 : (seg < 8) ? 81 : 0;
            rx_idle_pct = (seg < 4) ? 81 : (seg < 8) ? 36 : 0;
            case ($urandom_range(0, 3))
                0:       id = 16'h0000;
                1:       id = 16'hffff;
                default: id = 16'($urandom);
            endcase
            // timeout only loads at the limit, so its top value is harmless here
            program_regs(LIMIT_MAX, 16'($urandom_range(1, 4)),
                         (seg == 5) ? 16'hffff : 16'($urandom_range(0, 8)), id,
                         SIZE_W'($urandom_range(0, 31)), {$urandom, $urandom},
                         {$urandom, $urandom});
            repeat (SEGMENT_WORDS) put_random_word();
        end

        // Zero limit: the next send attempt or accepted reply ends the session
        drain_results();
        program_regs(16'h0000, 16'hffff, 16'($urandom_range(0, 8)), sb.echo_id,
                     SIZE_W'($urandom_range(0, 31)), {$urandom, $urandom},
                     {$urandom, $urandom});
        while (!sb.session_over) put_random_word();
        repeat (20) put_random_word();
        drain_results();

        $display("Run covered %0d words over %0d register settings: %0d requests sent,",
                 sb.words, n_settings, sb.n_sent);
        $display("  %0d replies accepted, %0d dropped, %0d quiet results; session ended: %0b",
                 sb.n_accepted, sb.n_dropped, sb.n_none, sb.session_over);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
